@@ hdl/si_pkg.sv @@
// package for the segment intersection pipeline
// holds beat types, stage record types and fixed widths; no dependencies
package si_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 34;
  localparam int CROSS_W = 35;
  localparam int SMAG_W  = 16;
  localparam int DXR_W   = 33;
  localparam int RXS_W   = 34;
  localparam int FRAC_W  = 8;
  localparam int NUM_W   = SMAG_W + DXR_W;
  localparam int REM_W   = NUM_W + FRAC_W + 1;
  localparam int QUO_W   = 24;
  localparam int PT_W    = 24;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
  } seg_t;

  typedef struct packed {
    logic                   hit;
    logic                   point_valid;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
  } res_t;

  // classified pair leaving the front stages
  typedef struct packed {
    logic                      hit;
    logic                      pv;
    logic                      negx;
    logic                      negy;
    logic [SMAG_W-1:0]         sxmag;
    logic [SMAG_W-1:0]         symag;
    logic [DXR_W-1:0]          dxrmag;
    logic [RXS_W-1:0]          rxsmag;
    logic signed [COORD_W-1:0] q0x;
    logic signed [COORD_W-1:0] q0y;
  } front_t;

  // record carried through the divider stages
  typedef struct packed {
    logic                      hit;
    logic                      pv;
    logic                      negx;
    logic                      negy;
    logic signed [COORD_W-1:0] q0x;
    logic signed [COORD_W-1:0] q0y;
    logic [RXS_W-1:0]          dmag;
    logic [REM_W-1:0]          remx;
    logic [REM_W-1:0]          remy;
    logic [QUO_W-1:0]          qx;
    logic [QUO_W-1:0]          qy;
  } div_t;

endpackage

@@ hdl/segment_intersection.sv @@
// segment intersection top: front stages, scale stage, divider chain, output
// register; one beat per cycle throughput while the result slot is free or
// being taken, set by a fully pipelined 24-stage one-bit-per-stage divider
// the whole pipe advances together and holds while a result waits unread
// synchronous active-high reset clears all valid bits; payload is not reset
// depends on si_pkg, si_front, si_div_step
module segment_intersection (
  input  logic            clk,
  input  logic            rst,
  input  logic            seg_valid,
  output logic            seg_ready,
  input  si_pkg::seg_t    seg,
  output logic            res_valid,
  input  logic            res_ready,
  output si_pkg::res_t    res
);

  logic en;
  logic fv, sv;
  si_pkg::front_t f;
  si_pkg::div_t   sc;
  logic           dv [0:si_pkg::QUO_W];
  si_pkg::div_t   dd [0:si_pkg::QUO_W];
  logic signed [si_pkg::QUO_W:0]   qsx, qsy;
  logic signed [si_pkg::QUO_W+1:0] px, py;
  logic [si_pkg::NUM_W-1:0] numx, numy;

  // global advance: move whenever the output slot is free or being taken
  assign en = !res_valid || res_ready;
  assign seg_ready = en;

  si_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(seg_valid), .seg(seg),
    .out_valid(fv), .out(f)
  );

  // scale stage: numerator magnitudes |s| * |dxr| * 256
  assign numx = f.sxmag * f.dxrmag;
  assign numy = f.symag * f.dxrmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (en) begin
      sv <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.hit  <= f.hit;
      sc.pv   <= f.pv;
      sc.negx <= f.negx;
      sc.negy <= f.negy;
      sc.q0x  <= f.q0x;
      sc.q0y  <= f.q0y;
      sc.dmag <= f.rxsmag;
      sc.remx <= {1'b0, numx, si_pkg::FRAC_W'(0)};
      sc.remy <= {1'b0, numy, si_pkg::FRAC_W'(0)};
      sc.qx   <= '0;
      sc.qy   <= '0;
    end
  end

  assign dv[0] = sv;
  assign dd[0] = sc;

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < si_pkg::QUO_W; i++) begin : g_div
    si_div_step #(.BIT(si_pkg::QUO_W - 1 - i)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[i]), .in(dd[i]),
      .out_valid(dv[i+1]), .out(dd[i+1])
    );
  end

  // sign restore and offset by the second start point
  always_comb begin
    qsx = dd[si_pkg::QUO_W].negx ? -$signed({1'b0, dd[si_pkg::QUO_W].qx})
                                 :  $signed({1'b0, dd[si_pkg::QUO_W].qx});
    qsy = dd[si_pkg::QUO_W].negy ? -$signed({1'b0, dd[si_pkg::QUO_W].qy})
                                 :  $signed({1'b0, dd[si_pkg::QUO_W].qy});
    px = ((si_pkg::QUO_W+2)'(dd[si_pkg::QUO_W].q0x) <<< si_pkg::FRAC_W)
         + (si_pkg::QUO_W+2)'(qsx);
    py = ((si_pkg::QUO_W+2)'(dd[si_pkg::QUO_W].q0y) <<< si_pkg::FRAC_W)
         + (si_pkg::QUO_W+2)'(qsy);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dv[si_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit         <= dd[si_pkg::QUO_W].hit;
      res.point_valid <= dd[si_pkg::QUO_W].pv;
      res.point_x     <= dd[si_pkg::QUO_W].pv ? px[si_pkg::PT_W-1:0] : '0;
      res.point_y     <= dd[si_pkg::QUO_W].pv ? py[si_pkg::PT_W-1:0] : '0;
    end
  end

  // a computed point always comes with a hit
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.point_valid |-> res.hit)
    else $error("point without hit");

  // no point means zeroed coordinates
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.point_valid |-> res.point_x == '0 && res.point_y == '0)
    else $error("stale point on miss");

  // a stalled result is held until taken
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result dropped during stall");

endmodule

@@ hdl/si_front.sv @@
// front stages: differences, products, cross products, classification
// depends on si_pkg
module si_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  si_pkg::seg_t     seg,
  output logic             out_valid,
  output si_pkg::front_t   out
);

  logic v1, v2, v3;
  logic signed [si_pkg::DIFF_W-1:0] dx, dy, rx, ry, sx, sy;
  logic xs1, ys1;
  logic signed [si_pkg::COORD_W-1:0] q0x1, q0y1;
  logic signed [si_pkg::PROD_W-1:0] dxry, dyrx, dxsy, dysx, rxsy, rysx;
  logic signed [si_pkg::DIFF_W-1:0] sx2, sy2, sx3, sy3;
  logic xs2, ys2, xs3, ys3;
  logic signed [si_pkg::COORD_W-1:0] q0x2, q0y2, q0x3, q0y3;
  logic signed [si_pkg::CROSS_W-1:0] dxr, dxs, rxs;
  logic signed [si_pkg::DIFF_W-1:0] qmp1x, qmp1y;
  logic t_in, u_in, dxr_zero, rxs_zero;
  logic signed [si_pkg::CROSS_W-1:0] dxr_neg, rxs_neg;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  assign qmp1x = si_pkg::DIFF_W'(seg.second_start_x) - si_pkg::DIFF_W'(seg.first_end_x);
  assign qmp1y = si_pkg::DIFF_W'(seg.second_start_y) - si_pkg::DIFF_W'(seg.first_end_y);

  // stage 1: differences and straddle flags
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= si_pkg::DIFF_W'(seg.second_start_x) - si_pkg::DIFF_W'(seg.first_start_x);
      dy <= si_pkg::DIFF_W'(seg.second_start_y) - si_pkg::DIFF_W'(seg.first_start_y);
      rx <= si_pkg::DIFF_W'(seg.first_end_x) - si_pkg::DIFF_W'(seg.first_start_x);
      ry <= si_pkg::DIFF_W'(seg.first_end_y) - si_pkg::DIFF_W'(seg.first_start_y);
      sx <= si_pkg::DIFF_W'(seg.second_end_x) - si_pkg::DIFF_W'(seg.second_start_x);
      sy <= si_pkg::DIFF_W'(seg.second_end_y) - si_pkg::DIFF_W'(seg.second_start_y);
      xs1 <= (seg.second_start_x < seg.first_start_x) != qmp1x[si_pkg::DIFF_W-1];
      ys1 <= (seg.second_start_y < seg.first_start_y) != qmp1y[si_pkg::DIFF_W-1];
      q0x1 <= seg.second_start_x;
      q0y1 <= seg.second_start_y;
    end
  end

  // stage 2: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      dxry <= dx * ry;
      dyrx <= dy * rx;
      dxsy <= dx * sy;
      dysx <= dy * sx;
      rxsy <= rx * sy;
      rysx <= ry * sx;
      sx2 <= sx;
      sy2 <= sy;
      xs2 <= xs1;
      ys2 <= ys1;
      q0x2 <= q0x1;
      q0y2 <= q0y1;
    end
  end

  // stage 3: cross products
  always_ff @(posedge clk) begin
    if (en) begin
      dxr <= si_pkg::CROSS_W'(dxry) - si_pkg::CROSS_W'(dyrx);
      dxs <= si_pkg::CROSS_W'(dxsy) - si_pkg::CROSS_W'(dysx);
      rxs <= si_pkg::CROSS_W'(rxsy) - si_pkg::CROSS_W'(rysx);
      sx3 <= sx2;
      sy3 <= sy2;
      xs3 <= xs2;
      ys3 <= ys2;
      q0x3 <= q0x2;
      q0y3 <= q0y2;
    end
  end

  // range checks of t and u against [0,1] without division
  always_comb begin
    dxr_zero = (dxr == '0);
    rxs_zero = (rxs == '0);
    dxr_neg  = -dxr;
    rxs_neg  = -rxs;
    if (!rxs[si_pkg::CROSS_W-1]) begin
      t_in = !dxs[si_pkg::CROSS_W-1] && (dxs <= rxs);
      u_in = !dxr[si_pkg::CROSS_W-1] && (dxr <= rxs);
    end else begin
      t_in = (dxs <= 0) && (dxs >= rxs);
      u_in = (dxr <= 0) && (dxr >= rxs);
    end
  end

  // stage 4: classification and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      out.hit <= dxr_zero ? (xs3 || ys3) : (!rxs_zero && t_in && u_in);
      out.pv <= !dxr_zero && !rxs_zero && t_in && u_in;
      out.negx <= sx3[si_pkg::DIFF_W-1] ^ dxr[si_pkg::CROSS_W-1] ^ rxs[si_pkg::CROSS_W-1];
      out.negy <= sy3[si_pkg::DIFF_W-1] ^ dxr[si_pkg::CROSS_W-1] ^ rxs[si_pkg::CROSS_W-1];
      out.sxmag <= sx3[si_pkg::DIFF_W-1] ? si_pkg::SMAG_W'(-sx3) : si_pkg::SMAG_W'(sx3);
      out.symag <= sy3[si_pkg::DIFF_W-1] ? si_pkg::SMAG_W'(-sy3) : si_pkg::SMAG_W'(sy3);
      out.dxrmag <= dxr[si_pkg::CROSS_W-1] ? si_pkg::DXR_W'(dxr_neg) : si_pkg::DXR_W'(dxr);
      out.rxsmag <= rxs[si_pkg::CROSS_W-1] ? si_pkg::RXS_W'(rxs_neg) : si_pkg::RXS_W'(rxs);
      out.q0x <= q0x3;
      out.q0y <= q0y3;
    end
  end

endmodule

@@ hdl/si_div_step.sv @@
// one restoring divide stage: one quotient bit for each of the x and y lanes
// depends on si_pkg
module si_div_step #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  si_pkg::div_t  in,
  output logic          out_valid,
  output si_pkg::div_t  out
);

  logic [si_pkg::REM_W-1:0] dsh;
  logic gex, gey;
  si_pkg::div_t out_next;

  // shifted divisor, trial compares, conditional subtract and quotient shift
  always_comb begin
    dsh = si_pkg::REM_W'(in.dmag) << BIT;
    gex = (in.remx >= dsh);
    gey = (in.remy >= dsh);
    out_next = in;
    out_next.remx = gex ? in.remx - dsh : in.remx;
    out_next.remy = gey ? in.remy - dsh : in.remy;
    out_next.qx = {in.qx[si_pkg::QUO_W-2:0], gex};
    out_next.qy = {in.qy[si_pkg::QUO_W-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      out <= out_next;
    end
  end

endmodule

@@ test/segment_checker.sv @@
// checker for the segment intersection block: watches both channels,
// predicts each result from the segment pair and compares; depends on si_pkg
`timescale 1ns / 1ps

module segment_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         seg_valid,
  input  logic         seg_ready,
  input  si_pkg::seg_t seg,
  input  logic         res_valid,
  input  logic         res_ready,
  input  si_pkg::res_t res,
  output int           errors,
  output int           pending
);

  si_pkg::res_t crossings[$];

  // true when num/den lies in the unit interval, den nonzero
  function automatic bit ratio_in_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic si_pkg::res_t predict_crossing(si_pkg::seg_t s);
    longint p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
    longint dx, dy, rx, ry, sx, sy, dxr, dxs, rxs, px, py;
    si_pkg::res_t o;
    p0x = s.first_start_x;  p0y = s.first_start_y;
    p1x = s.first_end_x;    p1y = s.first_end_y;
    q0x = s.second_start_x; q0y = s.second_start_y;
    q1x = s.second_end_x;   q1y = s.second_end_y;
    dx = q0x - p0x; dy = q0y - p0y;
    rx = p1x - p0x; ry = p1y - p0y;
    sx = q1x - q0x; sy = q1y - q0y;
    dxr = dx * ry - dy * rx;
    dxs = dx * sy - dy * sx;
    rxs = rx * sy - ry * sx;
    o = '0;
    if (dxr == 0) begin
      // collinear: start of second straddles the first in x or y
      o.hit = (((q0x - p0x) < 0) != ((q0x - p1x) < 0)) ||
              (((q0y - p0y) < 0) != ((q0y - p1y) < 0));
    end else if (rxs != 0 && ratio_in_unit(dxs, rxs) && ratio_in_unit(dxr, rxs)) begin
      // division in longint truncates toward zero
      px = q0x * 256 + (sx * dxr * 256) / rxs;
      py = q0y * 256 + (sy * dxr * 256) / rxs;
      o.hit = 1'b1;
      o.point_valid = 1'b1;
      o.point_x = px[23:0];
      o.point_y = py[23:0];
    end
    return o;
  endfunction

  // input beats push a prediction, output beats pop and compare
  always @(posedge clk) begin
    si_pkg::res_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (seg_valid && seg_ready) crossings.push_back(predict_crossing(seg));
      if (res_valid && res_ready) begin
        if (crossings.size() == 0) begin
          if (errors < 10) $display("unexpected result beat %p", res);
          errors <= errors + 1;
        end else begin
          want = crossings.pop_front();
          if (res.hit !== want.hit || res.point_valid !== want.point_valid ||
              res.point_x !== want.point_x || res.point_y !== want.point_y) begin
            if (errors < 10)
              $display({"mismatch: expected hit=%0b pv=%0b x=%0d y=%0d, ",
                        "got hit=%0b pv=%0b x=%0d y=%0d"},
                       want.hit, want.point_valid, want.point_x, want.point_y,
                       res.hit, res.point_valid, res.point_x, res.point_y);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= crossings.size();
  end
endmodule

@@ test/testbench.sv @@
// top of the segment intersection test: clock, reset, stimulus and verdict
// depends on si_pkg, segment_intersection and segment_checker
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_ready;
  si_pkg::seg_t seg = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  si_pkg::res_t res;
  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  bit recv_hold = 1'b0;
  longint cycles = 0;

  segment_intersection i_dut (.*);
  segment_checker i_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // guard against a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off
  always @(negedge clk) begin
    if (recv_hold) res_ready <= 1'b0;
    else res_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  // entered at a falling edge; leaves valid high so beats can follow back to back
  task automatic send_pair(si_pkg::seg_t s);
    while ($urandom_range(99) < send_idle) begin
      seg_valid <= 1'b0;
      @(negedge clk);
    end
    seg_valid <= 1'b1;
    seg <= s;
    @(posedge clk);
    while (!seg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // pairs that are crossing, collinear or parallel, with random content
  function automatic si_pkg::seg_t random_pair();
    si_pkg::seg_t s;
    logic signed [15:0] ax, ay, k;
    s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(5))
      0: begin
        // start of the second lies on the line of the first
        ax = 16'($signed($urandom_range(200)) - 100);
        ay = 16'($signed($urandom_range(200)) - 100);
        k = 16'($signed($urandom_range(8)) - 4);
        s.first_end_x = s.first_start_x + ax; s.first_end_y = s.first_start_y + ay;
        s.second_start_x = s.first_start_x + k * ax;
        s.second_start_y = s.first_start_y + k * ay;
      end
      1: begin
        // parallel offset
        s.second_end_x = s.second_start_x + s.first_end_x - s.first_start_x;
        s.second_end_y = s.second_start_y + s.first_end_y - s.first_start_y;
      end
      2: begin
        // crossing around the origin
        s.first_start_x = -16'($urandom_range(30000)); s.first_end_x = 16'($urandom_range(30000));
        s.first_start_y = 16'($signed($urandom_range(2000)) - 1000);
        s.first_end_y = 16'($signed($urandom_range(2000)) - 1000);
        s.second_start_y = -16'($urandom_range(30000)); s.second_end_y = 16'($urandom_range(30000));
        s.second_start_x = 16'($signed($urandom_range(2000)) - 1000);
        s.second_end_x = 16'($signed($urandom_range(2000)) - 1000);
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_phase(int n, int sidle, int ridle);
    send_idle = sidle;
    recv_idle = ridle;
    repeat (n) send_pair(random_pair());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, crossing, collinear, parallel, degenerate
    send_pair('0);
    send_pair({8{16'h8000}});
    send_pair({8{16'h7fff}});
    send_pair({16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    send_pair({16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
    send_pair({16'd0, 16'd0, 16'd10, 16'd10, 16'd0, 16'd10, 16'd10, 16'd0});
    send_pair({16'd0, 16'd0, 16'd10, 16'd0, 16'd5, 16'd0, 16'd20, 16'd0});
    send_pair({16'd0, 16'd0, 16'd10, 16'd0, 16'd15, 16'd0, 16'd20, 16'd0});
    send_pair({16'd0, 16'd0, 16'd10, 16'd0, 16'd0, 16'd5, 16'd10, 16'd5});
    send_pair({16'd0, 16'd0, 16'd10, 16'd0, 16'd20, 16'd5, 16'd20, -16'd5});
    send_pair({16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3});
    send_pair({16'd0, 16'd0, 16'd3, 16'd7, 16'd3, 16'd7, 16'd9, -16'd2});
    send_pair({16'd0, 16'd0, 16'd7, 16'd0, -16'd3, 16'd1, 16'd4, -16'd2});
    send_pair({-16'd5, -16'd5, 16'd5, 16'd5, -16'd5, 16'd5, 16'd5, -16'd4});

    // long receiver hold-off while the sender keeps offering pairs
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk);
        recv_hold = 1'b0;
      end
      send_phase(60, 0, 0);
    join

    send_phase(360, 17, 63);
    send_phase(360, 63, 17);
    send_phase(360, 0, 0);
    seg_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/si_pkg.sv
hdl/si_front.sv
hdl/si_div_step.sv
hdl/segment_intersection.sv
test/segment_checker.sv
test/testbench.sv
